// ----- hdl/mms_pkg.sv -----
// shared types and constants for the motor move supervisor
`timescale 1ns / 1ps

package mms_pkg;

  localparam logic [1:0] OP_MOVE  = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_CHECK = 2'd3;

  localparam logic [2:0] STATUS_NONE    = 3'd0;
  localparam logic [2:0] STATUS_RUNNING = 3'd1;
  localparam logic [2:0] STATUS_REACHED = 3'd2;
  localparam logic [2:0] STATUS_STALLED = 3'd3;
  localparam logic [2:0] STATUS_FREE    = 3'd4;

  localparam logic REG_MAX_RPM   = 1'b0;
  localparam logic REG_SLOW_DUTY = 1'b1;

  localparam logic [15:0] MAX_RPM_RESET   = 16'd100;
  localparam logic [7:0]  SLOW_DUTY_RESET = 8'd100;

  localparam logic [31:0] SLOW_ZONE = 32'd75;
  localparam logic [31:0] STALL_MS  = 32'd300;
  localparam logic [7:0]  DUTY_MAX  = 8'd255;

  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [1:0]  op;
    logic        clockwise;
    logic [31:0] target_centi_revs;
    logic [15:0] speed_rpm;
    logic [15:0] run_duty;
    logic [15:0] measured_speed;
    logic [31:0] done_centi_revs;
    logic [31:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  duty;
    logic        bridge_in1;
    logic        bridge_in2;
    logic [2:0]  status;
    logic [15:0] reported_rpm;
  } res_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] diff;
    logic        borrow;
  } alu_res_t;

endpackage

// ----- hdl/mms_cmd_if.sv -----
// command channel between a source and the supervisor
`timescale 1ns / 1ps

interface mms_cmd_if;
  import mms_pkg::*;

  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/mms_res_if.sv -----
// result channel from the supervisor to a sink
`timescale 1ns / 1ps

interface mms_res_if;
  import mms_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/mms_alu.sv -----
// shared 32-bit subtract and borrow unit used by the clamp, scale, divide and check steps
`timescale 1ns / 1ps

module mms_alu (
  input  mms_pkg::alu_req_t req,
  output mms_pkg::alu_res_t res
);
  logic [32:0] wide;

  assign wide       = {1'b0, req.a} - {1'b0, req.b};
  assign res.diff   = wide[31:0];
  assign res.borrow = wide[32];
endmodule

// ----- hdl/motor_move_supervisor.sv -----
// motor move supervisor top level: command sequencer and state registers
`timescale 1ns / 1ps

// Takes one command at a time and returns one result per command. Free run, stop and
// a check that finds the motor free running or idle go straight to the result stage.
// A supervised check runs four subtractions on the shared 32-bit subtractor (distance
// left, time since progress, time since start, done versus target). A move runs clamp,
// the scaling by 255 and an 8-step restoring division of the scaled speed by max_rpm,
// all on the same subtractor; a move of zero distance ends after the clamp. The next
// command is taken while a result still waits at the output.

module motor_move_supervisor (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_data,
  mms_cmd_if.sink          cmd,
  mms_res_if.source        res
);
  import mms_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CLAMP    = 4'd1;
  localparam logic [3:0] S_MUL      = 4'd2;
  localparam logic [3:0] S_DIV      = 4'd3;
  localparam logic [3:0] S_CK_NEAR  = 4'd4;
  localparam logic [3:0] S_CK_IDLE  = 4'd5;
  localparam logic [3:0] S_CK_START = 4'd6;
  localparam logic [3:0] S_CK_DONE  = 4'd7;
  localparam logic [3:0] S_FINISH   = 4'd8;

  logic [3:0]  state;
  cmd_t        cmd_r;
  logic [15:0] max_rpm;
  logic [7:0]  slow_duty;
  logic [15:0] target_speed;
  logic [31:0] target_distance;
  logic [31:0] start_time;
  logic [31:0] last_progress;
  logic [31:0] last_progress_time;
  logic        free_running;
  logic [7:0]  current_duty;
  logic [1:0]  bridge;
  logic [2:0]  status_r;
  logic [15:0] rpm_r;
  logic        idle_gt;
  logic        start_gt;
  logic [15:0] rem;
  logic [7:0]  div_lo;
  logic [7:0]  quot;
  logic [DIV_CNT_W-1:0] cnt;
  logic        res_valid;
  res_t        res_data;

  alu_req_t    alu_req;
  alu_res_t    alu_res;
  logic [15:0] clamped;
  logic [7:0]  quot_next;

  mms_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  always_comb begin
    alu_req = '0;
    unique case (state)
      S_CLAMP: begin
        alu_req.a = {16'd0, max_rpm};
        alu_req.b = {16'd0, cmd_r.speed_rpm};
      end
      S_MUL: begin
        alu_req.a = {8'd0, target_speed, 8'd0};
        alu_req.b = {16'd0, target_speed};
      end
      S_DIV: begin
        alu_req.a = {15'd0, rem, div_lo[7]};
        alu_req.b = {16'd0, max_rpm};
      end
      S_CK_NEAR: begin
        alu_req.a = target_distance;
        alu_req.b = cmd_r.done_centi_revs;
      end
      S_CK_IDLE: begin
        alu_req.a = cmd_r.now_ms;
        alu_req.b = last_progress_time;
      end
      S_CK_START: begin
        alu_req.a = cmd_r.now_ms;
        alu_req.b = start_time;
      end
      S_CK_DONE: begin
        alu_req.a = cmd_r.done_centi_revs;
        alu_req.b = target_distance;
      end
      default: alu_req = '0;
    endcase
  end

  assign clamped   = alu_res.borrow ? max_rpm : cmd_r.speed_rpm;
  assign quot_next = {quot[6:0], ~alu_res.borrow};

  assign cmd.ready = (state == S_IDLE);
  assign res.valid = res_valid;
  assign res.data  = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      max_rpm            <= MAX_RPM_RESET;
      slow_duty          <= SLOW_DUTY_RESET;
      target_speed       <= '0;
      target_distance    <= '0;
      start_time         <= '0;
      last_progress      <= '0;
      last_progress_time <= '0;
      free_running       <= 1'b0;
      current_duty       <= '0;
      bridge             <= '0;
      status_r           <= STATUS_NONE;
      rpm_r              <= '0;
      res_valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_RPM:   max_rpm   <= cfg_data;
          REG_SLOW_DUTY: slow_duty <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (res.valid && res.ready && state != S_FINISH) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cmd_r    <= cmd.data;
            status_r <= (cmd.data.op == OP_CHECK && free_running) ? STATUS_FREE
                                                                  : STATUS_NONE;
            rpm_r    <= '0;
            unique case (cmd.data.op)
              OP_MOVE: state <= S_CLAMP;
              OP_RUN: begin
                bridge       <= cmd.data.clockwise ? 2'b01 : 2'b10;
                free_running <= 1'b1;
                current_duty <= (|cmd.data.run_duty[15:8]) ? DUTY_MAX
                                                           : cmd.data.run_duty[7:0];
                state        <= S_FINISH;
              end
              OP_STOP: begin
                current_duty    <= '0;
                target_speed    <= '0;
                target_distance <= '0;
                start_time      <= '0;
                state           <= S_FINISH;
              end
              OP_CHECK: begin
                if (free_running) begin
                  state <= S_FINISH;
                end else if (target_speed == '0) begin
                  state <= S_FINISH;
                end else begin
                  state <= S_CK_NEAR;
                end
              end
              default: state <= S_FINISH;
            endcase
          end
        end

        S_CLAMP: begin
          bridge          <= cmd_r.clockwise ? 2'b01 : 2'b10;
          free_running    <= 1'b0;
          target_speed    <= clamped;
          target_distance <= cmd_r.target_centi_revs;
          if (cmd_r.target_centi_revs == '0) begin
            state <= S_FINISH;
          end else begin
            start_time <= cmd_r.now_ms;
            if (max_rpm == '0) begin
              current_duty <= '0;
              state        <= S_FINISH;
            end else begin
              state <= S_MUL;
            end
          end
        end

        S_MUL: begin
          // 255 * speed, quotient below 256 since speed <= max_rpm
          rem    <= alu_res.diff[23:8];
          div_lo <= alu_res.diff[7:0];
          quot   <= '0;
          cnt    <= '0;
          state  <= S_DIV;
        end

        S_DIV: begin
          rem    <= alu_res.borrow ? {rem[14:0], div_lo[7]} : alu_res.diff[15:0];
          div_lo <= {div_lo[6:0], 1'b0};
          quot   <= quot_next;
          cnt    <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            current_duty <= quot_next;
            state        <= S_FINISH;
          end
        end

        S_CK_NEAR: begin
          if (cmd_r.measured_speed != '0 && alu_res.diff < SLOW_ZONE) begin
            current_duty <= slow_duty;
          end
          state <= S_CK_IDLE;
        end

        S_CK_IDLE: begin
          idle_gt <= alu_res.diff > STALL_MS;
          state   <= S_CK_START;
        end

        S_CK_START: begin
          start_gt <= alu_res.diff > STALL_MS;
          state    <= S_CK_DONE;
        end

        S_CK_DONE: begin
          if (last_progress == cmd_r.done_centi_revs && idle_gt && start_gt) begin
            current_duty    <= '0;
            target_speed    <= '0;
            target_distance <= '0;
            start_time      <= '0;
            status_r        <= STATUS_STALLED;
          end else begin
            if (last_progress != cmd_r.done_centi_revs) begin
              last_progress      <= cmd_r.done_centi_revs;
              last_progress_time <= cmd_r.now_ms;
            end
            if (alu_res.borrow) begin
              status_r <= STATUS_RUNNING;
              rpm_r    <= target_speed;
            end else begin
              current_duty    <= '0;
              target_speed    <= '0;
              target_distance <= '0;
              start_time      <= '0;
              status_r        <= STATUS_REACHED;
            end
          end
          state <= S_FINISH;
        end

        S_FINISH: begin
          if (!res_valid || res.ready) begin
            res_valid             <= 1'b1;
            res_data.duty         <= current_duty;
            res_data.bridge_in1   <= bridge[0];
            res_data.bridge_in2   <= bridge[1];
            res_data.status       <= status_r;
            res_data.reported_rpm <= rpm_r;
            state                 <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("command taken while a command is in work");

  a_rpm_only_running: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.data.status != STATUS_RUNNING) |-> res.data.reported_rpm == '0)
    else $error("rpm reported outside running status");

  a_rpm_nonzero_running: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.data.status == STATUS_RUNNING) |-> res.data.reported_rpm != '0)
    else $error("running status with zero rpm");

  a_bridge_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(bridge[0] && bridge[1]))
    else $error("both bridge lines high");
`endif
endmodule

// ----- verif/motor_move_supervisor_tb.sv -----
// testbench for the motor move supervisor: directed and random commands against a predictor
`timescale 1ns / 1ps

module motor_move_supervisor_tb;
  import mms_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  mms_cmd_if cmd();
  mms_res_if res();

  motor_move_supervisor u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .res       (res)
  );

  // predicted registers and motor state
  logic [15:0] max_rpm_reg   = MAX_RPM_RESET;
  logic [7:0]  slow_duty_reg = SLOW_DUTY_RESET;
  logic [15:0] speed_set     = '0;
  logic [31:0] dist_set      = '0;
  logic [31:0] t_start       = '0;
  logic [31:0] progress      = '0;
  logic [31:0] progress_ms   = '0;
  logic        free_run      = 1'b0;
  logic [7:0]  duty_now      = '0;
  logic        line1         = 1'b0;
  logic        line2         = 1'b0;

  res_t pending_results[$];
  int   fail_count = 0;
  int   items_sent = 0;
  int   res_hold   = 0;
  bit   steady_cmd = 1'b0;
  bit   steady_res = 1'b0;

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void halt_drive();
    duty_now  = '0;
    speed_set = '0;
    t_start   = '0;
    dist_set  = '0;
  endfunction

  function automatic res_t apply_command(input cmd_t c);
    res_t        r;
    logic [31:0] scaled;
    r = '0;
    r.status = STATUS_NONE;
    case (c.op)
      OP_MOVE: begin
        line1     = c.clockwise;
        line2     = ~c.clockwise;
        free_run  = 1'b0;
        speed_set = (c.speed_rpm > max_rpm_reg) ? max_rpm_reg : c.speed_rpm;
        dist_set  = c.target_centi_revs;
        if (dist_set != 0) begin
          scaled   = (max_rpm_reg == 0) ? 32'd0 : speed_set * 32'd255 / max_rpm_reg;
          duty_now = (scaled > 32'd255) ? DUTY_MAX : scaled[7:0];
          t_start  = c.now_ms;
        end
      end
      OP_RUN: begin
        line1    = c.clockwise;
        line2    = ~c.clockwise;
        free_run = 1'b1;
        duty_now = (c.run_duty > 16'd255) ? DUTY_MAX : c.run_duty[7:0];
      end
      OP_STOP: halt_drive();
      default: begin
        if (free_run) begin
          r.status = STATUS_FREE;
        end else if (speed_set != 0) begin
          // slow-down zone uses the wrapped remaining distance
          if (c.measured_speed != 0 && (dist_set - c.done_centi_revs) < SLOW_ZONE)
            duty_now = slow_duty_reg;
          if (progress == c.done_centi_revs && (c.now_ms - progress_ms) > STALL_MS &&
              (c.now_ms - t_start) > STALL_MS) begin
            halt_drive();
            r.status = STATUS_STALLED;
          end else begin
            if (progress != c.done_centi_revs) begin
              progress_ms = c.now_ms;
              progress    = c.done_centi_revs;
            end
            if (c.done_centi_revs < dist_set) begin
              r.status       = STATUS_RUNNING;
              r.reported_rpm = speed_set;
            end else begin
              halt_drive();
              r.status = STATUS_REACHED;
            end
          end
        end
      end
    endcase
    r.duty       = duty_now;
    r.bridge_in1 = line1;
    r.bridge_in2 = line2;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // result side: random stalls on ready
  always @(posedge clk) begin
    if (res_hold > 0) begin
      res_hold <= res_hold - 1;
      res.ready <= 1'b0;
    end else if (!steady_res && $urandom_range(0, 3) == 0) begin
      res_hold <= pick_gap();
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, res.data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("duty", 32'(want.duty), 32'(res.data.duty));
        check_field("bridge_in1", 32'(want.bridge_in1), 32'(res.data.bridge_in1));
        check_field("bridge_in2", 32'(want.bridge_in2), 32'(res.data.bridge_in2));
        check_field("status", 32'(want.status), 32'(res.data.status));
        check_field("reported_rpm", 32'(want.reported_rpm), 32'(res.data.reported_rpm));
      end
    end
  end

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.op                = 2'($urandom_range(0, 3));
    c.clockwise         = 1'($urandom_range(0, 1));
    c.target_centi_revs = $urandom;
    c.speed_rpm         = 16'($urandom);
    c.run_duty          = 16'($urandom);
    c.measured_speed    = 16'($urandom);
    c.done_centi_revs   = $urandom;
    c.now_ms            = $urandom;
    return c;
  endfunction

  task automatic send_command(input cmd_t c);
    int gap;
    gap = steady_cmd ? 0 : pick_gap();
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.data  <= c;
    do begin
      @(posedge clk);
    end while (!cmd.ready);
    pending_results.push_back(apply_command(c));
    items_sent++;
  endtask

  task automatic send_move(input logic cw, input logic [31:0] target,
                           input logic [15:0] speed, input logic [31:0] now);
    cmd_t c;
    c = random_cmd();
    c.op = OP_MOVE;
    c.clockwise = cw;
    c.target_centi_revs = target;
    c.speed_rpm = speed;
    c.now_ms = now;
    send_command(c);
  endtask

  task automatic send_run(input logic cw, input logic [15:0] duty);
    cmd_t c;
    c = random_cmd();
    c.op = OP_RUN;
    c.clockwise = cw;
    c.run_duty = duty;
    send_command(c);
  endtask

  task automatic send_stop();
    cmd_t c;
    c = random_cmd();
    c.op = OP_STOP;
    send_command(c);
  endtask

  task automatic send_check(input logic [15:0] meas, input logic [31:0] done,
                            input logic [31:0] now);
    cmd_t c;
    c = random_cmd();
    c.op = OP_CHECK;
    c.measured_speed = meas;
    c.done_centi_revs = done;
    c.now_ms = now;
    send_command(c);
  endtask

  task automatic settle();
    cmd.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] rpm, input logic [7:0] slow);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_RPM;
    cfg_data  <= rpm;
    @(posedge clk);
    cfg_index <= REG_SLOW_DUTY;
    cfg_data  <= {8'd0, slow};
    @(posedge clk);
    cfg_we <= 1'b0;
    max_rpm_reg   = rpm;
    slow_duty_reg = slow;
  endtask

  task automatic test_directed_moves();
    send_check(16'd0, 32'd0, 32'd0);
    // zero distance keeps duty and start time, then stalls at once
    send_move(1'b1, 32'd0, 16'd40, 32'd1234);
    send_check(16'd7, 32'd0, 32'd1000);
    // speed above max clamps
    send_move(1'b1, 32'd1000, 16'hFFFF, 32'd5000);
    send_check(16'd0, 32'd10, 32'd5010);
    send_check(16'hFFFF, 32'd950, 32'd5020);
    send_check(16'd3, 32'd950, 32'd5320);
    send_check(16'd3, 32'd950, 32'd5321);
    // slow zone edges, then target reached
    send_move(1'b0, 32'd200, 16'd50, 32'd0);
    send_check(16'd1, 32'd125, 32'd10);
    send_check(16'd1, 32'd126, 32'd20);
    send_check(16'd1, 32'd200, 32'd30);
    // zero speed leaves the block idle
    send_move(1'b1, 32'hFFFF_FFFF, 16'd0, 32'd40);
    send_check(16'd5, 32'd5, 32'd50);
    // time and distance wrap
    send_move(1'b0, 32'd100, 16'd100, 32'hFFFF_FF00);
    send_check(16'd9, 32'd30, 32'h0000_0010);
    send_check(16'd9, 32'hFFFF_FFF0, 32'h0000_0020);
    // stall needs time since start above the limit too
    send_move(1'b1, 32'd500, 16'd60, 32'd1000);
    send_check(16'd2, 32'hFFFF_FFF0, 32'd1300);
    send_move(1'b1, 32'd500, 16'd60, 32'd1000);
    send_check(16'd2, 32'hFFFF_FFF0, 32'd1301);
  endtask

  task automatic test_free_run();
    send_run(1'b1, 16'hFFFF);
    send_check(16'd3, 32'd0, 32'd0);
    send_run(1'b0, 16'd256);
    send_run(1'b0, 16'd200);
    send_stop();
    send_check(16'd0, 32'd1, 32'd900);
    send_run(1'b1, 16'd0);
    send_run(1'b0, 16'd255);
  endtask

  task automatic test_register_extremes();
    write_regs(16'd1, 8'd0);
    send_move(1'b1, 32'd300, 16'hFFFF, 32'd0);
    send_check(16'd1, 32'd250, 32'd10);
    send_move(1'b0, 32'd300, 16'd0, 32'd20);
    write_regs(16'hFFFF, 8'd255);
    send_move(1'b0, 32'd300, 16'hFFFF, 32'd100);
    send_move(1'b1, 32'd300, 16'd1, 32'd100);
    send_move(1'b1, 32'd300, 16'd32768, 32'd100);
    send_check(16'hFFFF, 32'd280, 32'd120);
    write_regs(MAX_RPM_RESET, SLOW_DUTY_RESET);
  endtask

  task automatic move_sequence();
    logic [31:0] now;
    logic [31:0] tgt;
    logic [31:0] done;
    logic [15:0] speed;
    logic [15:0] meas;
    int          r;
    r = $urandom_range(0, 99);
    now = (r < 20) ? 32'hFFFF_FE00 + $urandom_range(0, 511) : $urandom;
    r = $urandom_range(0, 99);
    if (r < 5) tgt = 32'd0;
    else if (r < 65) tgt = $urandom_range(1, 2000);
    else if (r < 80) tgt = $urandom_range(1, 150);
    else if (r < 90) tgt = $urandom;
    else tgt = 32'hFFFF_FF00 + $urandom_range(0, 255);
    speed = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, max_rpm_reg)) : 16'($urandom);
    send_move(1'($urandom_range(0, 1)), tgt, speed, now);
    done = ($urandom_range(0, 3) == 0) ? progress : 32'd0;
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        done = done + $urandom_range(1, tgt / 8 + 1);
        now  = now + $urandom_range(1, 120);
      end else if (r < 75) begin
        now = now + $urandom_range(200, 450);
      end else if (r < 85) begin
        done = tgt - $urandom_range(0, 80);
        now  = now + $urandom_range(1, 40);
      end else if (r < 92) begin
        done = tgt + $urandom_range(0, 3);
        now  = now + $urandom_range(1, 40);
      end else begin
        done = $urandom;
        now  = $urandom;
      end
      meas = ($urandom_range(0, 99) < 15) ? 16'd0 : 16'($urandom_range(1, 65535));
      send_check(meas, done, now);
    end
    r = $urandom_range(0, 99);
    if (r < 20) send_stop();
    else if (r < 30) send_run(1'($urandom_range(0, 1)), 16'($urandom_range(0, 400)));
  endtask

  task automatic test_random_traffic();
    int          goal;
    int          r;
    logic [15:0] rpm;
    logic [7:0]  slow;
    cmd_t        c;
    for (int phase = 0; phase < 10; phase++) begin
      r = $urandom_range(0, 99);
      if (phase == 0) rpm = 16'd1;
      else if (phase == 1) rpm = 16'hFFFF;
      else if (r < 30) rpm = 16'($urandom_range(1, 10));
      else if (r < 70) rpm = 16'($urandom_range(11, 500));
      else rpm = 16'($urandom_range(1, 65535));
      if (phase == 2) slow = 8'd0;
      else if (phase == 3) slow = 8'd255;
      else slow = 8'($urandom);
      write_regs(rpm, slow);
      steady_cmd = (phase % 3 == 1);
      steady_res = (phase % 4 == 2);
      goal = items_sent + 110;
      while (items_sent < goal) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          move_sequence();
        end else if (r < 85) begin
          send_run(1'($urandom_range(0, 1)), 16'($urandom));
          repeat ($urandom_range(1, 3)) begin
            c = random_cmd();
            c.op = OP_CHECK;
            send_command(c);
          end
        end else begin
          send_command(random_cmd());
        end
      end
    end
    steady_cmd = 1'b0;
    steady_res = 1'b0;
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_MAX_RPM;
    cfg_data  <= '0;
    cmd.valid <= 1'b0;
    cmd.data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_moves();
    test_free_run();
    test_register_extremes();
    test_random_traffic();
    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
